@@ rtl/core/rkdv_pkg.sv @@
// Shared types, widths and helpers of the RK4 damped velocity derivative unit.
// No dependencies; imported by the channel interfaces and the top level.
package rkdv_pkg;

    localparam int MAX_DOF = 32;
    localparam int IDX_W   = $clog2(MAX_DOF);
    localparam int MADDR_W = 2 * IDX_W;
    localparam int DATA_W  = 32;
    localparam int FRAC    = 20;
    localparam int ACC_W   = 49;
    localparam int WS_W    = 48;
    localparam int DIV_W   = 35;
    localparam int TS_W    = 31;
    localparam int DOF_W   = 6;

    // divide by six as a multiply by ceil(2^36 / 6), exact below 2^35
    localparam int RECIP_W  = 34;
    localparam int RECIP_SH = 36;
    localparam int DSPLIT   = 18;
    localparam int DPP_W    = DSPLIT + RECIP_W;
    localparam int DPROD_W  = DPP_W + DSPLIT;
    localparam logic [RECIP_W-1:0] RECIP6 = 34'd11453246123;

    localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(5243);
    localparam logic [DOF_W-1:0] DOF_RESET = DOF_W'(MAX_DOF);

    typedef enum logic [2:0] {
        CMD_FORCE    = 3'd0,
        CMD_INV_MASS = 3'd1,
        CMD_FRICTION = 3'd2,
        CMD_VELOCITY = 3'd3,
        CMD_COMPUTE  = 3'd4
    } t_cmd;

    typedef enum logic {
        REG_TIME_STEP = 1'b0,
        REG_DOF       = 1'b1
    } t_reg_idx;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            sat32 = hi[DATA_W-1:0];
        end else if (x < lo) begin
            sat32 = lo[DATA_W-1:0];
        end else begin
            sat32 = x[DATA_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/rkdv_in_if.sv @@
// Input item channel: valid/ready handshake with command, indices and value.
// Depends on rkdv_pkg.
interface rkdv_in_if import rkdv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

@@ rtl/core/rkdv_out_if.sv @@
// Result channel: valid/ready handshake with one derivative element per beat.
// Depends on rkdv_pkg.
interface rkdv_out_if import rkdv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] derivative;
    logic [IDX_W-1:0]         index;
    logic                     last;

    modport source (output valid, derivative, index, last, input ready);
    modport sink   (input valid, derivative, index, last, output ready);
endinterface

@@ rtl/core/rk4_damped_velocity_derivative_unit.sv @@
// Load beats fill f, Minv, B and v, one element per beat.
// A compute beat runs four RK4 stages of v_dot = Minv (f - B v) on one shared
// multiply-accumulate unit fed from synchronous memories, then emits N result
// beats in index order with last on element N-1. N is the DOF register clamped
// to 1..MAX_DOF. A compute streams one product per cycle through the MAC,
// drains the multiply pipeline and writes back after each matrix row, then
// divides each result element by six as a reciprocal multiply split into low
// and high halves; a stalled result beat holds the sequence. No input beat
// is taken while a compute is under way. Depends on rkdv_pkg and the channels.
module rk4_damped_velocity_derivative_unit import rkdv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rkdv_in_if.sink           i_item,
    rkdv_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_ROW      = 12'b0000_0000_0010,
        ST_MAC      = 12'b0000_0000_0100,
        ST_DRAIN    = 12'b0000_0000_1000,
        ST_FIN_A    = 12'b0000_0001_0000,
        ST_FIN_B1   = 12'b0000_0010_0000,
        ST_FIN_B2   = 12'b0000_0100_0000,
        ST_FIN_B3   = 12'b0000_1000_0000,
        ST_OUT_RD   = 12'b0001_0000_0000,
        ST_OUT_LD   = 12'b0010_0000_0000,
        ST_OUT_DIV  = 12'b0100_0000_0000,
        ST_OUT_EMIT = 12'b1000_0000_0000
    } t_state;

    // configuration
    logic [TS_W-1:0]  r_time_step;
    logic [DOF_W-1:0] r_dof;
    logic             cfg_wr;
    logic [IDX_W-1:0] n_m1;

    // memories
    logic signed [DATA_W-1:0] fric_mem [MAX_DOF*MAX_DOF];
    logic signed [DATA_W-1:0] minv_mem [MAX_DOF*MAX_DOF];
    logic signed [DATA_W-1:0] f_mem    [MAX_DOF];
    logic signed [DATA_W-1:0] pv_mem   [MAX_DOF];
    logic signed [DATA_W-1:0] sv_mem   [MAX_DOF];
    logic signed [DATA_W-1:0] nf_mem   [MAX_DOF];
    logic signed [WS_W-1:0]   ws_mem   [MAX_DOF];
    logic [MAX_DOF-1:0]       r_pv_vld;

    logic signed [DATA_W-1:0] r_fric_q, r_minv_q, r_f_q, r_pv_q, r_sv_q, r_nf_q;
    logic signed [WS_W-1:0]   r_ws_q;

    // sequencer
    t_state           r_state, n_state;
    logic [1:0]       r_stage;
    logic             r_phase_b;
    logic [IDX_W-1:0] r_row, r_col;
    logic             r_drain;
    logic             r_v1, r_v2;
    logic signed [63:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_k;
    logic signed [63:0]       r_step;
    logic [DIV_W-1:0]         r_dvd;
    logic [DPROD_W-1:0]       r_dprod;
    logic [5:0]               r_dcnt;
    logic                     r_neg;

    logic r_o_valid;
    logic signed [DATA_W-1:0] r_o_deriv;
    logic [IDX_W-1:0]         r_o_index;
    logic                     r_o_last;

    logic in_acc, mac_issue, stream_pv, row_last;
    logic [MADDR_W-1:0] mat_waddr, mat_raddr;
    logic [IDX_W-1:0]   pv_raddr;
    logic signed [DATA_W-1:0] vec_q;
    logic signed [DATA_W-1:0] k_sat;
    logic signed [63:0] rnd_prod, step_rnd, nf64, sv64, div64;
    logic signed [WS_W-1:0] wk, ws_new, ws_mag;
    logic [DSPLIT-1:0] div_opd;
    logic [DPP_W-1:0]  div_pp;
    logic [DIV_W-1:0]  quot;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DOF) ? 32'(r_dof) : 32'(r_time_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TS_RESET;
            r_dof       <= DOF_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DOF) begin
                r_dof <= pwdata[DOF_W-1:0];
            end else begin
                r_time_step <= pwdata[TS_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_dof == '0) begin
            n_m1 = '0;
        end else if (r_dof > DOF_W'(MAX_DOF)) begin
            n_m1 = IDX_W'(MAX_DOF - 1);
        end else begin
            n_m1 = IDX_W'(r_dof - DOF_W'(1));
        end
    end

    assign in_acc       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == ST_IDLE);
    assign mac_issue    = (r_state == ST_MAC);
    assign stream_pv    = !r_phase_b && (r_stage == 2'd0);
    assign row_last     = (r_row == n_m1);
    assign mat_waddr    = {i_item.row, i_item.col};
    assign mat_raddr    = {r_row, r_col};
    assign pv_raddr     = (mac_issue && stream_pv) ? r_col : r_row;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (in_acc && i_item.cmd == CMD_FRICTION) fric_mem[mat_waddr] <= i_item.value;
        if (mac_issue && !r_phase_b) r_fric_q <= fric_mem[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_item.cmd == CMD_INV_MASS) minv_mem[mat_waddr] <= i_item.value;
        if (mac_issue && r_phase_b) r_minv_q <= minv_mem[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_item.cmd == CMD_FORCE) f_mem[i_item.row] <= i_item.value;
        if (r_state == ST_ROW) r_f_q <= f_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_item.cmd == CMD_VELOCITY) pv_mem[i_item.row] <= i_item.value;
        if (r_state == ST_ROW || (mac_issue && stream_pv)) begin
            r_pv_q <= r_pv_vld[pv_raddr] ? pv_mem[pv_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv_vld <= '0;
        end else if (in_acc && i_item.cmd == CMD_VELOCITY) begin
            r_pv_vld[i_item.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN_B3) sv_mem[r_row] <= sat32(sv64);
        if (mac_issue && !r_phase_b) r_sv_q <= sv_mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN_A) nf_mem[r_row] <= sat32(nf64);
        if (mac_issue && r_phase_b) r_nf_q <= nf_mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN_B1) ws_mem[r_row] <= ws_new;
        if (r_state == ST_ROW || r_state == ST_OUT_RD) r_ws_q <= ws_mem[r_row];
    end

    // datapath
    always_comb begin
        if (r_phase_b) begin
            vec_q = r_nf_q;
        end else if (r_stage == 2'd0) begin
            vec_q = r_pv_q;
        end else begin
            vec_q = r_sv_q;
        end
        rnd_prod = (r_prod + 64'sd524288) >>> FRAC;
        nf64     = 64'(r_f_q) - 64'(r_acc);
        // weight the k that is being registered this cycle
        k_sat    = sat32(64'(r_acc));
        wk       = (r_stage == 2'd1 || r_stage == 2'd2) ? (WS_W'(k_sat) <<< 1) : WS_W'(k_sat);
        ws_new   = ((r_stage == 2'd0) ? '0 : r_ws_q) + wk;
        // half steps for stages zero and one take one more bit of shift than stage two
        if (r_stage == 2'd2) begin
            step_rnd = (r_step + 64'sd524288) >>> FRAC;
        end else begin
            step_rnd = (r_step + 64'sd1048576) >>> (FRAC + 1);
        end
        sv64    = 64'(r_pv_q) + step_rnd;
        ws_mag  = r_ws_q[WS_W-1] ? -r_ws_q : r_ws_q;
        div_opd = r_dcnt[0] ? DSPLIT'(r_dvd[DIV_W-1:DSPLIT]) : r_dvd[DSPLIT-1:0];
        div_pp  = DPP_W'(div_opd) * DPP_W'(RECIP6);
        quot    = DIV_W'(r_dprod[DPROD_W-1:RECIP_SH]);
        div64   = r_neg ? -64'(quot) : 64'(quot);
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) r_prod <= 64'(r_phase_b ? r_minv_q : r_fric_q) * 64'(vec_q);
        if (r_state == ST_ROW) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + rnd_prod[ACC_W-1:0];
        end
        if (r_state == ST_FIN_B1) r_k <= k_sat;
        if (r_state == ST_FIN_B2) r_step <= 64'(r_k) * $signed({33'd0, r_time_step});
        if (r_state == ST_OUT_LD) begin
            r_dvd <= ws_mag[DIV_W-1:0] + DIV_W'(3);
            r_neg <= r_ws_q[WS_W-1];
        end else if (r_state == ST_OUT_DIV) begin
            // low half of the dividend first, then add the high half shifted up
            if (r_dcnt == '0) begin
                r_dprod <= DPROD_W'(div_pp);
            end else begin
                r_dprod <= r_dprod + (DPROD_W'(div_pp) << DSPLIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= mac_issue;
            r_v2 <= r_v1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc && i_item.cmd == CMD_COMPUTE) n_state = ST_ROW;
            ST_ROW:      n_state = ST_MAC;
            ST_MAC:      if (r_col == n_m1) n_state = ST_DRAIN;
            ST_DRAIN:    if (r_drain) n_state = r_phase_b ? ST_FIN_B1 : ST_FIN_A;
            ST_FIN_A:    n_state = ST_ROW;
            ST_FIN_B1: begin
                if (r_stage != 2'd3) begin
                    n_state = ST_FIN_B2;
                end else if (row_last) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_FIN_B2:   n_state = ST_FIN_B3;
            ST_FIN_B3:   n_state = ST_ROW;
            ST_OUT_RD:   n_state = ST_OUT_LD;
            ST_OUT_LD:   n_state = ST_OUT_DIV;
            ST_OUT_DIV:  if (r_dcnt == 6'd1) n_state = ST_OUT_EMIT;
            ST_OUT_EMIT: begin
                if (!r_o_valid || o_result.ready) n_state = row_last ? ST_IDLE : ST_OUT_RD;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stage   <= '0;
            r_phase_b <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_drain   <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_stage   <= '0;
                    r_phase_b <= 1'b0;
                    r_row     <= '0;
                end
                ST_ROW: begin
                    r_col   <= '0;
                    r_drain <= 1'b0;
                end
                ST_MAC:   r_col <= r_col + IDX_W'(1);
                ST_DRAIN: r_drain <= 1'b1;
                ST_FIN_A: begin
                    // advance to the k pass once every net force row is in
                    if (row_last) begin
                        r_row     <= '0;
                        r_phase_b <= 1'b1;
                    end else begin
                        r_row <= r_row + IDX_W'(1);
                    end
                end
                ST_FIN_B1: begin
                    if (r_stage == 2'd3) r_row <= row_last ? '0 : r_row + IDX_W'(1);
                end
                ST_FIN_B3: begin
                    if (row_last) begin
                        r_row     <= '0;
                        r_phase_b <= 1'b0;
                        r_stage   <= r_stage + 2'd1;
                    end else begin
                        r_row <= r_row + IDX_W'(1);
                    end
                end
                ST_OUT_LD:  r_dcnt <= '0;
                ST_OUT_DIV: r_dcnt <= r_dcnt + 6'd1;
                ST_OUT_EMIT: begin
                    if ((!r_o_valid || o_result.ready) && !row_last) r_row <= r_row + IDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    // output register; hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_OUT_EMIT && (!r_o_valid || o_result.ready)) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT_EMIT && (!r_o_valid || o_result.ready)) begin
            r_o_deriv <= sat32(div64);
            r_o_index <= r_row;
            r_o_last  <= row_last;
        end
    end

    assign o_result.valid      = r_o_valid;
    assign o_result.derivative = r_o_deriv;
    assign o_result.index      = r_o_index;
    assign o_result.last       = r_o_last;

endmodule
